FILE: hdl/stk_pkg.sv
// Shared types and codes for the sorted top-k insert table.
`default_nettype none
package stk_pkg;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 24;
    localparam int POS_W   = 3;
    localparam int FILL_W  = 4;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

endpackage
`default_nettype wire

FILE: hdl/stk_cell.sv
// One rank of the sorted table: compares against the new score and shifts from its neighbour.
`default_nettype none
module stk_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   ins,
    input  wire logic [stk_pkg::SCORE_W-1:0] new_score,
    input  wire logic [stk_pkg::TAG_W-1:0]   new_tag,
    input  wire stk_pkg::entry_t        prev_entry,
    input  wire logic                   prev_take,
    output stk_pkg::entry_t             entry,
    output logic                        take
);
    import stk_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    // ranks are a sorted prefix, so take is monotone along the chain
    assign take = !valid_reg || (new_score > data_reg.score);

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ins)
        begin
            priority if (prev_take)
            begin
                data_next  = prev_entry;
                valid_next = prev_entry.valid;
            end
            else if (take)
            begin
                data_next.score = new_score;
                data_next.tag   = new_tag;
                valid_next      = 1'b1;
            end
            else
            begin
                valid_next = valid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

endmodule
`default_nettype wire

FILE: hdl/sorted_top_k_insert_table_core.sv
// Top level of the sorted top-k insert table: cell chain, fill counter and result register.
//  channel | signals                                        | dir
//  in      | in_valid in_stall func new_score new_tag        | to block
//          | read_position                                  |
//  out     | out_valid out_stall entry_score entry_tag       | from block
//          | was_inserted insert_slot fill_count            |
// One transfer per cycle while in_stall is low: every cell compares and shifts in parallel in the
// accepting cycle, and the result is in the output register on the next one.
// rst_n clears all cell valid bits and the fill counter; the table starts empty.
// in_stall is high only while a result is held and out_stall is high.
`default_nettype none
module sorted_top_k_insert_table_core #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         func,
    input  wire logic [stk_pkg::SCORE_W-1:0]  new_score,
    input  wire logic [stk_pkg::TAG_W-1:0]    new_tag,
    input  wire logic [stk_pkg::POS_W-1:0]    read_position,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [stk_pkg::SCORE_W-1:0]       entry_score,
    output logic [stk_pkg::TAG_W-1:0]         entry_tag,
    output logic                              was_inserted,
    output logic [stk_pkg::POS_W-1:0]         insert_slot,
    output logic [stk_pkg::FILL_W-1:0]        fill_count
);
    import stk_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int READ_N = (TABLE_DEPTH < 8) ? TABLE_DEPTH : 8;

    entry_t            entries [TABLE_DEPTH];
    logic              takes   [TABLE_DEPTH];
    logic              accept;
    logic              ins;
    logic              full;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [31:0]       slot_acc;
    logic [31:0]       cnt_ext;
    logic [SCORE_W-1:0] rd_score;
    logic [TAG_W-1:0]  rd_tag;

    logic               out_valid_reg;
    logic [SCORE_W-1:0] entry_score_reg;
    logic [TAG_W-1:0]   entry_tag_reg;
    logic               was_inserted_reg;
    logic [POS_W-1:0]   insert_slot_reg;
    logic [FILL_W-1:0]  fill_count_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign ins      = accept && (func_t'(func) == FUNC_INSERT);
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                stk_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ins        (ins),
                    .new_score  (new_score),
                    .new_tag    (new_tag),
                    .prev_entry ('0),
                    .prev_take  (1'b0),
                    .entry      (entries[g]),
                    .take       (takes[g])
                );
            end
            else
            begin : g_body
                stk_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ins        (ins),
                    .new_score  (new_score),
                    .new_tag    (new_tag),
                    .prev_entry (entries[g-1]),
                    .prev_take  (takes[g-1]),
                    .entry      (entries[g]),
                    .take       (takes[g])
                );
            end
        end
    endgenerate

    // landing rank: the first cell that takes
    always_comb
    begin
        slot_acc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (takes[i] && (i == 0 || !takes[(i == 0) ? 0 : i - 1]))
            begin
                slot_acc = slot_acc | 32'(i);
            end
        end
    end

    always_comb
    begin
        rd_score = '0;
        rd_tag   = '0;
        for (int i = 0; i < READ_N; i++)
        begin
            if (read_position == POS_W'(i) && entries[i].valid)
            begin
                rd_score = entries[i].score;
                rd_tag   = entries[i].tag;
            end
        end
    end

    assign count_next = (ins && !full) ? count_reg + CNT_W'(1) : count_reg;
    assign cnt_ext    = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fill_count_reg <= cnt_ext[FILL_W-1:0];
            if (func_t'(func) == FUNC_READ)
            begin
                entry_score_reg  <= rd_score;
                entry_tag_reg    <= rd_tag;
                was_inserted_reg <= 1'b0;
                insert_slot_reg  <= '0;
            end
            else
            begin
                entry_score_reg  <= '0;
                entry_tag_reg    <= '0;
                was_inserted_reg <= takes[TABLE_DEPTH-1];
                insert_slot_reg  <= takes[TABLE_DEPTH-1] ? slot_acc[POS_W-1:0] : '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_score  = entry_score_reg;
    assign entry_tag    = entry_tag_reg;
    assign was_inserted = was_inserted_reg;
    assign insert_slot  = insert_slot_reg;
    assign fill_count   = fill_count_reg;

endmodule
`default_nettype wire

FILE: hdl/stk_checker.sv
// Port-level checks for the sorted top-k insert table, bound to the top level.
`default_nettype none
module stk_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        func,
    input wire logic [stk_pkg::SCORE_W-1:0] new_score,
    input wire logic [stk_pkg::TAG_W-1:0]   new_tag,
    input wire logic [stk_pkg::POS_W-1:0]   read_position,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [stk_pkg::SCORE_W-1:0] entry_score,
    input wire logic [stk_pkg::TAG_W-1:0]   entry_tag,
    input wire logic                        was_inserted,
    input wire logic [stk_pkg::POS_W-1:0]   insert_slot,
    input wire logic [stk_pkg::FILL_W-1:0]  fill_count
);
    import stk_pkg::*;

    // a transfer in always yields a result on the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(func) && $stable(new_score)
            && $stable(new_tag) && $stable(read_position))
        else $error("stalled input changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_score)
            && $stable(fill_count) && $stable(insert_slot))
        else $error("stalled result changed");

    a_insert_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_inserted |-> entry_score == '0 && entry_tag == '0)
        else $error("insert result carries entry data");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !was_inserted |-> insert_slot == '0)
        else $error("slot set without insertion");

endmodule

bind sorted_top_k_insert_table_core stk_checker u_stk_checker (.*);
`default_nettype wire

FILE: test/sorted_top_k_insert_table_core_tb.sv
// Testbench for the sorted top-k insert table: directed and random transfers against a model.
module sorted_top_k_insert_table_core_tb;
    import stk_pkg::*;

    localparam int TABLE_DEPTH   = 8;
    localparam int N_RANDOM      = 400;
    localparam int PAUSE_ROW     = 200;
    localparam int LONG_HOLD_AT  = 60;
    localparam int LONG_HOLD_LEN = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               ins;
        logic [POS_W-1:0]   slot;
        logic [FILL_W-1:0]  fill;
    } table_result_t;

    typedef struct packed {
        func_t              op;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic [POS_W-1:0]   pos;
        logic               has_exp;
        table_result_t      exp_res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                func = 1'b0;
    logic [SCORE_W-1:0]  new_score = '0;
    logic [TAG_W-1:0]    new_tag = '0;
    logic [POS_W-1:0]    read_position = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SCORE_W-1:0]  entry_score;
    logic [TAG_W-1:0]    entry_tag;
    logic                was_inserted;
    logic [POS_W-1:0]    insert_slot;
    logic [FILL_W-1:0]   fill_count;

    sorted_top_k_insert_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .new_score    (new_score),
        .new_tag      (new_tag),
        .read_position(read_position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .entry_score  (entry_score),
        .entry_tag    (entry_tag),
        .was_inserted (was_inserted),
        .insert_slot  (insert_slot),
        .fill_count   (fill_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // directed rows; has_exp marks a hand-typed result, the rest go to the predictor
    stim_row_t directed_ops [25] = '{
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd0}},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd7, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd0}},
        '{FUNC_INSERT, 32'hFFFF_FFFF, 24'hFFFFFF, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd0, 4'd1}},
        '{FUNC_INSERT, 32'h0000_0000, 24'h000000, 3'd7, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd1, 4'd2}},
        '{FUNC_READ,   32'hFFFF_FFFF, 24'hFFFFFF, 3'd1, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd2}},
        '{FUNC_INSERT, 32'h0000_0000, 24'h000001, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd2, 4'd3}},
        '{FUNC_INSERT, 32'hFFFF_FFFF, 24'h123456, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd1, 4'd4}},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd1, 1'b1,
          '{32'hFFFF_FFFF, 24'h123456, 1'b0, 3'd0, 4'd4}},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd4, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd4}},
        '{FUNC_INSERT, 32'h8000_0000, 24'hAAAAAA, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd2, 4'd5}},
        '{FUNC_INSERT, 32'h0000_0005, 24'h555555, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd3, 4'd6}},
        '{FUNC_INSERT, 32'h0000_0005, 24'h555556, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd4, 4'd7}},
        '{FUNC_INSERT, 32'h0000_0001, 24'h000111, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd5, 4'd8}},
        '{FUNC_INSERT, 32'h0000_0000, 24'h0F0F0F, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd8}},
        '{FUNC_INSERT, 32'h0000_0000, 24'hFFFFFF, 3'd7, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd8}},
        '{FUNC_INSERT, 32'h0000_0002, 24'h222222, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd5, 4'd8}},
        '{FUNC_INSERT, 32'hFFFF_FFFF, 24'h654321, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd2, 4'd8}},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd7, 1'b1,
          '{32'h0000_0001, 24'h000111, 1'b0, 3'd0, 4'd8}},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd0, 1'b1,
          '{32'hFFFF_FFFF, 24'hFFFFFF, 1'b0, 3'd0, 4'd8}},
        '{FUNC_INSERT, 32'h0000_0001, 24'h000000, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b0, 3'd0, 4'd8}},
        '{FUNC_INSERT, 32'hFFFF_FFFE, 24'h000000, 3'd0, 1'b1, '{32'h0, 24'h0, 1'b1, 3'd3, 4'd8}},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd2, 1'b0, '0},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd3, 1'b0, '0},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd5, 1'b0, '0},
        '{FUNC_READ,   32'h0000_0000, 24'h000000, 3'd6, 1'b0, '0}
    };

    stim_row_t     stim [$];
    table_result_t pending_results [$];

    logic [SCORE_W-1:0] rank_score_q [TABLE_DEPTH];
    logic [TAG_W-1:0]   rank_tag_q [TABLE_DEPTH];
    int                 rank_fill = 0;

    int n_in = 0;
    int n_out = 0;
    int err_cnt = 0;
    int cycles = 0;

    function automatic table_result_t rank_table_step(func_t op, logic [SCORE_W-1:0] score,
                                                      logic [TAG_W-1:0] tag,
                                                      logic [POS_W-1:0] pos);
        table_result_t r;
        int            slot;
        int            last;
        int            i;
        r = '0;
        if (op == FUNC_READ)
        begin
            if (pos < rank_fill)
            begin
                r.score = rank_score_q[pos];
                r.tag   = rank_tag_q[pos];
            end
        end
        else
        begin
            slot = rank_fill;
            for (i = rank_fill - 1; i >= 0; i--)
                if (score > rank_score_q[i])
                    slot = i;
            if (slot < TABLE_DEPTH)
            begin
                last = (rank_fill < TABLE_DEPTH) ? rank_fill : TABLE_DEPTH - 1;
                for (i = last; i > slot; i--)
                begin
                    rank_score_q[i] = rank_score_q[i-1];
                    rank_tag_q[i]   = rank_tag_q[i-1];
                end
                rank_score_q[slot] = score;
                rank_tag_q[slot]   = tag;
                if (rank_fill < TABLE_DEPTH)
                    rank_fill++;
                r.ins  = 1'b1;
                r.slot = slot[POS_W-1:0];
            end
        end
        r.fill = rank_fill[FILL_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, table_result_t want, table_result_t got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
        begin
            $write("%s: want score %h tag %h ins %b slot %0d fill %0d, ",
                   what, want.score, want.tag, want.ins, want.slot, want.fill);
            $display("got score %h tag %h ins %b slot %0d fill %0d",
                     got.score, got.tag, got.ins, got.slot, got.fill);
        end
    endtask

    // sender
    int next_row = 0;
    int gap_left = 0;
    int drv_row = 0;

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (next_row == PAUSE_ROW && (n_in != n_out || in_valid))
                in_valid <= 1'b0;
            else if (next_row < stim.size())
            begin
                in_valid      <= 1'b1;
                func          <= stim[next_row].op;
                new_score     <= stim[next_row].score;
                new_tag       <= stim[next_row].tag;
                read_position <= stim[next_row].pos;
                drv_row       <= next_row;
                next_row      <= next_row + 1;
                case ((next_row / 40) % 3)
                    0: gap_left <= 0;
                    1: gap_left <= ($urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
                    default:
                        if ($urandom_range(0, 99) < 20)
                            gap_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                                     : $urandom_range(8, 30);
                        else
                            gap_left <= 0;
                endcase
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    int rx_seen = 0;
    int rx_hold = 0;
    bit rx_long_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                rx_seen <= rx_seen + 1;
            if (rx_hold > 0)
            begin
                rx_hold   <= rx_hold - 1;
                out_stall <= 1'b1;
            end
            else if (!rx_long_done && rx_seen >= LONG_HOLD_AT)
            begin
                rx_long_done <= 1'b1;
                rx_hold      <= LONG_HOLD_LEN - 1;
                out_stall    <= 1'b1;
            end
            else
            begin
                case ((rx_seen / 50) % 3)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    default:
                        if ($urandom_range(0, 99) < 15)
                        begin
                            rx_hold   <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                                      : $urandom_range(8, 30);
                            out_stall <= 1'b1;
                        end
                        else
                            out_stall <= 1'b0;
                endcase
            end
        end
    end

    // checker: predicts on each input transfer, compares on each output transfer
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        table_result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {entry_score, entry_tag, was_inserted, insert_slot, fill_count};
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        flag_mismatch("result mismatch", want, got);
                end
                n_out <= n_out + 1;
            end
            if (in_valid && !in_stall)
            begin
                pred = rank_table_step(func_t'(func), new_score, new_tag, read_position);
                if (stim[drv_row].has_exp)
                    pending_results.push_back(stim[drv_row].exp_res);
                else
                    pending_results.push_back(pred);
                n_in <= n_in + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_top_k_insert_table_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        int        cls;
        foreach (directed_ops[i])
            stim.push_back(directed_ops[i]);
        // random: scores lean on extremes, ties at the top and small values that mostly get dropped
        for (int i = 0; i < N_RANDOM; i++)
        begin
            row     = '0;
            row.op  = ($urandom_range(0, 99) < 55) ? FUNC_INSERT : FUNC_READ;
            row.tag = TAG_W'($urandom_range(0, 24'hFFFFFF));
            row.pos = POS_W'($urandom_range(0, 7));
            cls     = $urandom_range(0, 9);
            case (cls)
                0: row.score = '0;
                1: row.score = '1;
                2, 3: row.score = $urandom_range(0, 15);
                4: row.score = 32'hFFFF_FFFF - $urandom_range(0, 7);
                default: row.score = $urandom;
            endcase
            stim.push_back(row);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (n_out < stim.size())
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("sorted_top_k_insert_table_core_tb: done, clean");
        else
            $display("sorted_top_k_insert_table_core_tb: done, errors");
        $finish;
    end

endmodule
